// File: rtl/core/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
package sfs_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int LIST_DEPTH = 16;
  localparam int LIST_AW    = 4;
  localparam int CFG_DW     = 13;
  localparam int CFG_AW     = 3;

  localparam logic [CFG_AW-1:0] CFG_FRAME_COUNT     = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_FIRST_FRAME     = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_LAST_FRAME      = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_BOUNCE_MODE     = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_START_BACKWARD  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT    = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_SEQUENCE_LENGTH = 3'd6;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET     = 2'd1,
    REQ_LOAD    = 2'd2,
    REQ_RESTART = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [7:0]  frame_number;
    logic [3:0]  entry_index;
    logic [7:0]  entry_frame;
  } req_t;

  typedef struct packed {
    logic [7:0]  current_frame;
    logic [19:0] frame_y;
    logic        backward;
    logic [3:0]  list_position;
  } rsp_t;

  typedef struct packed {
    logic [8:0]  frame_count;
    logic [7:0]  first_frame;
    logic [8:0]  last_frame;
    logic        bounce_mode;
    logic        start_backward;
    logic [12:0] frame_height;
    logic [4:0]  sequence_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         shown_frame;
    logic               direction_down;
    logic [LIST_AW-1:0] list_index;
  } state_t;

  typedef struct packed {
    logic               en;
    logic [LIST_AW-1:0] addr;
    logic [7:0]         data;
  } list_wr_t;

endpackage

// File: rtl/core/sfs_list_regs.sv
// Frame list register file: one write port, one combinational read port.
module sfs_list_regs (
  input  logic                        clk_i,
  input  sfs_pkg::list_wr_t           wr_i,
  input  logic [sfs_pkg::LIST_AW-1:0] rd_addr_i,
  output logic [7:0]                  rd_data_o
);

  logic [7:0] entry_q [sfs_pkg::LIST_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      entry_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = entry_q[rd_addr_i];

endmodule

// File: rtl/core/sfs_step.sv
// Next-state and result logic for one sequencer request.
module sfs_step (
  input  sfs_pkg::cfg_t               cfg_i,
  input  sfs_pkg::state_t             state_i,
  input  sfs_pkg::req_t               req_i,
  input  logic [7:0]                  list_data_i,
  output logic [sfs_pkg::LIST_AW-1:0] list_addr_o,
  output sfs_pkg::list_wr_t           list_wr_o,
  output sfs_pkg::state_t             state_o,
  output sfs_pkg::rsp_t               rsp_o
);

  logic [8:0]                  cnt;
  logic [4:0]                  len;
  logic [7:0]                  last;
  logic                        list_mode;
  logic [7:0]                  fsel;
  logic [sfs_pkg::LIST_AW-1:0] set_idx;
  logic [4:0]                  inc;
  logic [sfs_pkg::LIST_AW-1:0] tick_idx;
  logic                        tick_dir;
  logic [7:0]                  f;
  logic [8:0]                  fp1;
  logic [20:0]                 prod;

  always_comb begin
    cnt = cfg_i.frame_count;
    if (cfg_i.frame_count == 9'd0) begin
      cnt = 9'd1;
    end else if (cfg_i.frame_count > 9'(sfs_pkg::MAX_FRAMES)) begin
      cnt = 9'(sfs_pkg::MAX_FRAMES);
    end
    len = (cfg_i.sequence_length > 5'(sfs_pkg::LIST_DEPTH)) ?
          5'(sfs_pkg::LIST_DEPTH) : cfg_i.sequence_length;
    last = cfg_i.last_frame[8] ? 8'(cnt - 9'd1) : cfg_i.last_frame[7:0];
    list_mode = (len != 5'd0);

    // set frame and restart share one path
    fsel = (req_i.req_type == sfs_pkg::REQ_RESTART) ? cfg_i.first_frame : req_i.frame_number;
    set_idx = (fsel >= 8'(len)) ? '0 : fsel[sfs_pkg::LIST_AW-1:0];

    // list index step
    inc = {1'b0, state_i.list_index} + 5'd1;
    tick_idx = state_i.list_index;
    tick_dir = state_i.direction_down;
    if (state_i.direction_down) begin
      if (state_i.list_index == '0) begin
        if (cfg_i.bounce_mode) begin
          tick_dir = 1'b0;
          tick_idx = (len <= 5'd1) ? 4'(len - 5'd1) : 4'd1;
        end else begin
          tick_idx = 4'(len - 5'd1);
        end
      end else begin
        tick_idx = state_i.list_index - 4'd1;
      end
    end else begin
      if (inc >= len) begin
        if (cfg_i.bounce_mode) begin
          tick_dir = 1'b1;
          tick_idx = (inc < 5'd2) ? 4'd0 : 4'(inc - 5'd2);
        end else begin
          tick_idx = '0;
        end
      end else begin
        tick_idx = inc[3:0];
      end
    end

    list_addr_o = (req_i.req_type == sfs_pkg::REQ_TICK) ? tick_idx : set_idx;

    list_wr_o.en   = (req_i.req_type == sfs_pkg::REQ_LOAD);
    list_wr_o.addr = req_i.entry_index;
    list_wr_o.data = req_i.entry_frame;

    state_o = state_i;
    fp1 = {1'b0, state_i.shown_frame} + 9'd1;
    f = fsel;
    case (req_i.req_type)
      sfs_pkg::REQ_TICK: begin
        if (list_mode) begin
          state_o.list_index = tick_idx;
          state_o.direction_down = tick_dir;
          f = ({1'b0, tick_idx} < len) ? list_data_i : state_i.shown_frame;
          if ({1'b0, f} >= cnt) begin
            f = cfg_i.first_frame;
          end
        end else if (state_i.direction_down) begin
          if (state_i.shown_frame <= cfg_i.first_frame) begin
            if (cfg_i.bounce_mode) begin
              state_o.direction_down = 1'b0;
              f = (fp1 > {1'b0, last}) ? last : fp1[7:0];
            end else begin
              f = last;
            end
          end else begin
            f = state_i.shown_frame - 8'd1;
          end
        end else begin
          if (state_i.shown_frame >= last) begin
            if (cfg_i.bounce_mode) begin
              state_o.direction_down = 1'b1;
              f = (state_i.shown_frame == 8'd0) ? 8'd0 : state_i.shown_frame - 8'd1;
            end else begin
              f = cfg_i.first_frame;
            end
          end else begin
            f = fp1[7:0];
          end
        end
        state_o.shown_frame = f;
      end
      sfs_pkg::REQ_SET, sfs_pkg::REQ_RESTART: begin
        if (req_i.req_type == sfs_pkg::REQ_RESTART) begin
          state_o.direction_down = cfg_i.start_backward;
        end
        if (list_mode) begin
          state_o.list_index = set_idx;
          f = list_data_i;
        end
        if ({1'b0, f} >= cnt) begin
          f = cfg_i.first_frame;
        end
        if (f < cfg_i.first_frame) begin
          f = last;
        end
        state_o.shown_frame = f;
      end
      default: begin
        state_o = state_i;
      end
    endcase

    prod = 21'(cfg_i.frame_height) * 21'(state_o.shown_frame);
    rsp_o.current_frame = state_o.shown_frame;
    rsp_o.frame_y       = prod[20] ? '1 : prod[19:0];
    rsp_o.backward      = state_o.direction_down;
    rsp_o.list_position = state_o.list_index;
  end

endmodule

// File: rtl/core/sprite_frame_sequencer.sv
// Sprite frame sequencer top level: request register, state, result register.
// A request waits in the request register until its result is registered.
// Throughput: one request per cycle unless a result waits for rsp_ready_i,
// through the combinational step logic between the request and result registers.
// Reset: configuration returns to its defaults, frame, direction and list
// position clear to zero; frame list contents are undefined until loaded.
module sprite_frame_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfs_pkg::CFG_AW-1:0]  cfg_index_i,
  input  logic [sfs_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  sfs_pkg::req_t               req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output sfs_pkg::rsp_t               rsp_o
);

  sfs_pkg::cfg_t               cfg_q;
  sfs_pkg::state_t             state_q;
  sfs_pkg::state_t             state_d;
  sfs_pkg::req_t               req_q;
  logic                        req_valid_q;
  logic                        req_valid_d;
  sfs_pkg::rsp_t               rsp_q;
  sfs_pkg::rsp_t               rsp_d;
  logic                        rsp_valid_q;
  logic                        rsp_valid_d;
  logic                        advance;
  logic [sfs_pkg::LIST_AW-1:0] list_addr;
  logic [7:0]                  list_data;
  sfs_pkg::list_wr_t           list_wr;
  sfs_pkg::list_wr_t           list_wr_gated;

  assign advance     = req_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !req_valid_q || advance;
  assign req_valid_d = (req_valid_i && req_ready_o) || (req_valid_q && !advance);
  assign rsp_valid_d = advance || (rsp_valid_q && !rsp_ready_i);

  always_comb begin
    list_wr_gated    = list_wr;
    list_wr_gated.en = list_wr.en && advance;
  end

  sfs_list_regs u_list (
    .clk_i    (clk_i),
    .wr_i     (list_wr_gated),
    .rd_addr_i(list_addr),
    .rd_data_o(list_data)
  );

  sfs_step u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .req_i      (req_q),
    .list_data_i(list_data),
    .list_addr_o(list_addr),
    .list_wr_o  (list_wr),
    .state_o    (state_d),
    .rsp_o      (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count     <= 9'd1;
      cfg_q.first_frame     <= 8'd0;
      cfg_q.last_frame      <= 9'h1FF;
      cfg_q.bounce_mode     <= 1'b0;
      cfg_q.start_backward  <= 1'b0;
      cfg_q.frame_height    <= 13'd1;
      cfg_q.sequence_length <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sfs_pkg::CFG_FRAME_COUNT:     cfg_q.frame_count     <= cfg_wdata_i[8:0];
        sfs_pkg::CFG_FIRST_FRAME:     cfg_q.first_frame     <= cfg_wdata_i[7:0];
        sfs_pkg::CFG_LAST_FRAME:      cfg_q.last_frame      <= cfg_wdata_i[8:0];
        sfs_pkg::CFG_BOUNCE_MODE:     cfg_q.bounce_mode     <= cfg_wdata_i[0];
        sfs_pkg::CFG_START_BACKWARD:  cfg_q.start_backward  <= cfg_wdata_i[0];
        sfs_pkg::CFG_FRAME_HEIGHT:    cfg_q.frame_height    <= cfg_wdata_i;
        sfs_pkg::CFG_SEQUENCE_LENGTH: cfg_q.sequence_length <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_advance_fills_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> rsp_valid_o)
    else $error("computed request did not reach the result register");

  a_hold_pending_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !advance |=> req_valid_q && $stable(req_q))
    else $error("pending request dropped or changed");

  a_load_keeps_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && req_q.req_type == sfs_pkg::REQ_LOAD |=> state_q == $past(state_q))
    else $error("list load changed sequencer state");

  a_restart_direction : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && req_q.req_type == sfs_pkg::REQ_RESTART
      |=> rsp_o.backward == $past(cfg_q.start_backward))
    else $error("restart did not load start direction");

endmodule

// File: verif/sprite_frame_sequencer_test.sv
// Self-checking testbench for the sprite frame sequencer: random and directed requests.
module sprite_frame_sequencer_test;

  localparam int BOUNCE_STEP = 2;
  localparam int Y_CEIL = 1048575;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 24;
  localparam int PHASE_ITEMS = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sfs_pkg::CFG_AW-1:0] cfg_index_i = '0;
  logic [sfs_pkg::CFG_DW-1:0] cfg_wdata_i = '0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  sfs_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  sfs_pkg::rsp_t rsp_o;

  sprite_frame_sequencer dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i(req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o(rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sfs_pkg::cfg_t cfg_shadow;
  logic [7:0] seq_frame = '0;
  logic seq_down = 1'b0;
  int seq_pos = 0;
  logic [7:0] seq_list [sfs_pkg::LIST_DEPTH];

  sfs_pkg::req_t req_backlog[$];
  sfs_pkg::rsp_t frame_expect_q[$];
  int fault_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  bit send_steady = 1'b0;
  int hold_left = 0;
  bit hold_steady = 1'b0;

  function automatic int count_eff();
    int c = int'(cfg_shadow.frame_count);
    if (c == 0) c = 1;
    if (c > sfs_pkg::MAX_FRAMES) c = sfs_pkg::MAX_FRAMES;
    return c;
  endfunction

  function automatic int last_eff();
    int l = int'(cfg_shadow.last_frame);
    if (cfg_shadow.last_frame[8]) return count_eff() - 1;
    return l;
  endfunction

  function automatic int len_eff();
    int n = int'(cfg_shadow.sequence_length);
    if (n > sfs_pkg::LIST_DEPTH) n = sfs_pkg::LIST_DEPTH;
    return n;
  endfunction

  function automatic void jump_to(int f);
    int n = len_eff();
    int first = int'(cfg_shadow.first_frame);
    if (n > 0) begin
      if (f >= n) f = 0;
      seq_pos = f;
      f = int'(seq_list[f]);
    end
    if (f >= count_eff()) f = first;
    if (f < first) f = last_eff();
    seq_frame = f[7:0];
  endfunction

  function automatic void step_tick();
    int n = len_eff();
    int first = int'(cfg_shadow.first_frame);
    int last = last_eff();
    int i = seq_pos;
    int f = int'(seq_frame);
    if (n > 0) begin
      if (seq_down) begin
        i--;
        if (i < 0) begin
          if (cfg_shadow.bounce_mode) begin
            seq_down = 1'b0;
            i += BOUNCE_STEP;
            if (i >= n) i = n - 1;
          end else begin
            i = n - 1;
          end
        end
      end else begin
        i++;
        if (i >= n) begin
          if (cfg_shadow.bounce_mode) begin
            seq_down = 1'b1;
            i -= BOUNCE_STEP;
            if (i < 0) i = 0;
          end else begin
            i = 0;
          end
        end
      end
      seq_pos = i;
      if (i < n) seq_frame = seq_list[i];
      if (int'(seq_frame) >= count_eff()) seq_frame = cfg_shadow.first_frame;
    end else begin
      if (seq_down) begin
        f--;
        if (f < first) begin
          if (cfg_shadow.bounce_mode) begin
            seq_down = 1'b0;
            f += BOUNCE_STEP;
            if (f > last) f = last;
          end else begin
            f = last;
          end
        end
      end else begin
        f++;
        if (f > last) begin
          if (cfg_shadow.bounce_mode) begin
            seq_down = 1'b1;
            f -= BOUNCE_STEP;
            if (f < 0) f = 0;
          end else begin
            f = first;
          end
        end
      end
      seq_frame = f[7:0];
    end
  endfunction

  function automatic sfs_pkg::rsp_t advance_sequencer(sfs_pkg::req_t r);
    sfs_pkg::rsp_t o;
    longint y;
    case (r.req_type)
      sfs_pkg::REQ_TICK: step_tick();
      sfs_pkg::REQ_SET: jump_to(int'(r.frame_number));
      sfs_pkg::REQ_LOAD: seq_list[r.entry_index] = r.entry_frame;
      sfs_pkg::REQ_RESTART: begin
        seq_down = cfg_shadow.start_backward;
        jump_to(int'(cfg_shadow.first_frame));
      end
      default: ;
    endcase
    y = longint'(cfg_shadow.frame_height) * longint'(seq_frame);
    if (y > Y_CEIL) y = Y_CEIL;
    o.current_frame = seq_frame;
    o.frame_y = y[19:0];
    o.backward = seq_down;
    o.list_position = seq_pos[3:0];
    return o;
  endfunction

  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      fault_count++;
    end
  endfunction

  function automatic void queue_req(sfs_pkg::req_type_e kind, logic [7:0] fnum,
                                    logic [3:0] slot, logic [7:0] val);
    sfs_pkg::req_t r;
    r.req_type = kind;
    r.frame_number = fnum;
    r.entry_index = slot;
    r.entry_frame = val;
    req_backlog = {req_backlog, r};
  endfunction

  function automatic sfs_pkg::req_t draw_request();
    sfs_pkg::req_t r;
    int pick = $urandom_range(0, 99);
    r.req_type = pick < 60 ? sfs_pkg::REQ_TICK :
                 pick < 75 ? sfs_pkg::REQ_SET :
                 pick < 85 ? sfs_pkg::REQ_LOAD : sfs_pkg::REQ_RESTART;
    r.frame_number = 8'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 20));
    r.entry_index = 4'($urandom_range(0, 15));
    r.entry_frame = 8'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 20));
    return r;
  endfunction

  function automatic sfs_pkg::cfg_t make_setting(int count, int first, int last, int bounce,
                                                 int back, int height, int len);
    sfs_pkg::cfg_t c;
    c.frame_count = count[8:0];
    c.first_frame = first[7:0];
    c.last_frame = last[8:0];
    c.bounce_mode = bounce[0];
    c.start_backward = back[0];
    c.frame_height = height[12:0];
    c.sequence_length = len[4:0];
    return c;
  endfunction

  function automatic sfs_pkg::cfg_t draw_setting();
    int count, cnt, first, last, height, len;
    case ($urandom_range(0, 7))
      0: count = 0;
      1: count = 511;
      2: count = 256;
      3, 4: count = $urandom_range(1, 256);
      default: count = $urandom_range(2, 20);
    endcase
    cnt = count == 0 ? 1 : (count > sfs_pkg::MAX_FRAMES ? sfs_pkg::MAX_FRAMES : count);
    case ($urandom_range(0, 5))
      0: first = 0;
      1: first = 255;
      default: first = $urandom_range(0, (cnt - 1) / 2);
    endcase
    case ($urandom_range(0, 7))
      0: last = 'h1FF;
      1: last = 'h100 | $urandom_range(0, 255);
      2: last = 0;
      3: last = 255;
      default: last = first < cnt ? $urandom_range(first, cnt - 1) : cnt - 1;
    endcase
    case ($urandom_range(0, 7))
      0: height = 0;
      1: height = 8191;
      2: height = 4096;
      3: height = 1;
      default: height = $urandom_range(1, 4096);
    endcase
    case ($urandom_range(0, 11))
      0: len = 1;
      1: len = 2;
      2: len = 16;
      3: len = 17;
      4: len = 31;
      5: len = $urandom_range(1, 16);
      default: len = 0;
    endcase
    return make_setting(count, first, last, $urandom_range(0, 1), $urandom_range(0, 1),
                        height, len);
  endfunction

  task automatic write_reg(logic [sfs_pkg::CFG_AW-1:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[sfs_pkg::CFG_DW-1:0];
    case (idx)
      sfs_pkg::CFG_FRAME_COUNT: cfg_shadow.frame_count = value[8:0];
      sfs_pkg::CFG_FIRST_FRAME: cfg_shadow.first_frame = value[7:0];
      sfs_pkg::CFG_LAST_FRAME: cfg_shadow.last_frame = value[8:0];
      sfs_pkg::CFG_BOUNCE_MODE: cfg_shadow.bounce_mode = value[0];
      sfs_pkg::CFG_START_BACKWARD: cfg_shadow.start_backward = value[0];
      sfs_pkg::CFG_FRAME_HEIGHT: cfg_shadow.frame_height = value[12:0];
      sfs_pkg::CFG_SEQUENCE_LENGTH: cfg_shadow.sequence_length = value[4:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(sfs_pkg::cfg_t c);
    write_reg(sfs_pkg::CFG_FRAME_COUNT, 32'(c.frame_count));
    write_reg(sfs_pkg::CFG_FIRST_FRAME, 32'(c.first_frame));
    write_reg(sfs_pkg::CFG_LAST_FRAME, 32'(c.last_frame));
    write_reg(sfs_pkg::CFG_BOUNCE_MODE, 32'(c.bounce_mode));
    write_reg(sfs_pkg::CFG_START_BACKWARD, 32'(c.start_backward));
    write_reg(sfs_pkg::CFG_FRAME_HEIGHT, 32'(c.frame_height));
    write_reg(sfs_pkg::CFG_SEQUENCE_LENGTH, 32'(c.sequence_length));
  endtask

  task automatic drain();
    while (req_backlog.size() != 0 || req_valid_i || frame_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_req
    logic launch;
    sfs_pkg::req_t next_req;
    launch = req_valid_i;
    next_req = req_i;
    if (rst_ni) begin
      if (req_valid_i && req_ready_o) begin
        frame_expect_q = {frame_expect_q, advance_sequencer(req_i)};
        launch = 1'b0;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : $urandom_range(0, 16);
      end
      if (!launch) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_backlog.size() > 0) begin
          next_req = req_backlog.pop_front();
          launch = 1'b1;
        end
      end
    end
    req_valid_i <= launch;
    req_i <= next_req;
  end

  always @(posedge clk_i) begin : watch_rsp
    logic take;
    sfs_pkg::rsp_t want;
    take = rsp_ready_i;
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (frame_expect_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual frame %0d",
                   $time, rsp_o.current_frame);
          fault_count++;
        end else begin
          want = frame_expect_q.pop_front();
          check_field("current_frame", 32'(want.current_frame), 32'(rsp_o.current_frame));
          check_field("frame_y", 32'(want.frame_y), 32'(rsp_o.frame_y));
          check_field("backward", 32'(want.backward), 32'(rsp_o.backward));
          check_field("list_position", 32'(want.list_position), 32'(rsp_o.list_position));
        end
        if ($urandom_range(0, 39) == 0) hold_steady = !hold_steady;
        hold_left = hold_steady ? 0 : $urandom_range(0, 16);
        take = (hold_left == 0);
      end else if (!rsp_ready_i) begin
        if (hold_left > 0) hold_left--;
        if (hold_left == 0) take = 1'b1;
      end
    end
    rsp_ready_i <= take;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cfg_shadow = make_setting(1, 0, 'h1FF, 0, 0, 1, 0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill every list slot before list mode can read one
    for (int i = 0; i < sfs_pkg::LIST_DEPTH; i++)
      queue_req(sfs_pkg::REQ_LOAD, 8'(i * 17), 4'(i), 8'(i * 17));
    queue_req(sfs_pkg::REQ_TICK, 8'd0, 4'd15, 8'd255);
    queue_req(sfs_pkg::REQ_SET, 8'd255, 4'd0, 8'd0);
    queue_req(sfs_pkg::REQ_SET, 8'd0, 4'd0, 8'd0);
    queue_req(sfs_pkg::REQ_RESTART, 8'd0, 4'd0, 8'd0);
    drain();

    apply_setting(make_setting(8, 2, 5, 1, 1, 4096, 0));
    queue_req(sfs_pkg::REQ_RESTART, 8'd0, 4'd0, 8'd0);
    repeat (6) queue_req(sfs_pkg::REQ_TICK, 8'd0, 4'd0, 8'd0);
    queue_req(sfs_pkg::REQ_SET, 8'd7, 4'd0, 8'd0);
    queue_req(sfs_pkg::REQ_SET, 8'd1, 4'd0, 8'd0);
    queue_req(sfs_pkg::REQ_SET, 8'd200, 4'd0, 8'd0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_setting(make_setting(511, 0, 'h1FF, 0, 0, 8191, 0));
        1: apply_setting(make_setting(0, 255, 0, 1, 1, 0, 31));
        2: apply_setting(make_setting(256, 0, 255, 1, 0, 4096, 16));
        3: apply_setting(make_setting(16, 3, 'h100, 0, 1, 1, 1));
        default: apply_setting(draw_setting());
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) req_backlog = {req_backlog, draw_request()};
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
